// ===== sv/rsi_pkg.sv =====
// Shared constants, types and width helpers for the ray/sphere intersection core.
`default_nettype none

package rsi_pkg;

  // Default fixed-point formats: coordinates Q15.8 in 24 bits, directions Q1.14.
  localparam int COORD_WIDTH_DEF   = 24;
  localparam int DIR_FRAC_BITS_DEF = 14;

  // Result distance is unsigned Q.8 and saturates at all ones.
  localparam int              DIST_W   = 25;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Radius register resets to 1.0 in Q.8.
  localparam int RADIUS_RESET = 256;

  // Configuration register map.
  localparam int                   CFG_IDX_W     = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = CFG_IDX_W'(3);

  // Control flags that travel with each transaction down the pipeline.
  typedef struct packed {
    logic valid;
    logic disc_neg;
  } rsi_flags_t;

  // Width of b = floor(dot(offset, dir) / 2^frac). The fraction bits of the
  // direction cancel, so only the coordinate width matters.
  function automatic int b_width(int cw);
    return cw + 5;
  endfunction

  // Width of the discriminant as the arithmetic carries it: exact, but never
  // more than 64 bits, since wider values wrap modulo 2^64.
  function automatic int disc_width(int cw);
    return ((2 * cw + 12) > 64) ? 64 : (2 * cw + 12);
  endfunction

endpackage

`default_nettype wire

// ===== sv/ray_sphere_intersect_core.sv =====
// Ray/sphere intersection core: top level with configuration, skid and output stage.
//
// Tests each ray (origin in signed Q.8, direction in signed Q1.DIR_FRAC_BITS,
// assumed unit length) against one sphere whose center and radius are held in
// configuration registers, and returns a hit flag and the nearest nonnegative
// distance in unsigned Q.8 (zero on a miss, saturated at all ones). The core
// takes one ray per clock unless a result is held off, and returns one result
// per ray, in order. Five front stages form the offset, products, b and c,
// b*b and the discriminant; the square root adds one stage per root bit; one
// output stage rounds, subtracts and saturates. A stall on the result side
// holds the whole pipeline; a one-entry skid on the input keeps in_stall a
// register output, so one more ray is taken while a result waits. Write the
// configuration registers only while no ray is in flight.
`default_nettype none

module ray_sphere_intersect_core #(
  parameter int COORD_WIDTH   = rsi_pkg::COORD_WIDTH_DEF,
  parameter int DIR_FRAC_BITS = rsi_pkg::DIR_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [rsi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [COORD_WIDTH-1:0]            cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [COORD_WIDTH-1:0]     in_origin_x,
  input  wire logic signed [COORD_WIDTH-1:0]     in_origin_y,
  input  wire logic signed [COORD_WIDTH-1:0]     in_origin_z,
  input  wire logic signed [DIR_FRAC_BITS+1:0]   in_dir_x,
  input  wire logic signed [DIR_FRAC_BITS+1:0]   in_dir_y,
  input  wire logic signed [DIR_FRAC_BITS+1:0]   in_dir_z,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_hit,
  output logic [rsi_pkg::DIST_W-1:0]             out_hit_distance
);

  localparam int CW     = COORD_WIDTH;
  localparam int DW     = DIR_FRAC_BITS + 2;
  localparam int RW     = COORD_WIDTH - 1;
  localparam int PAY_W  = 3 * CW + 3 * DW;
  localparam int B_W    = rsi_pkg::b_width(COORD_WIDTH);
  localparam int DISC_W = rsi_pkg::disc_width(COORD_WIDTH);
  localparam int RT_W   = DISC_W / 2;
  localparam int RAD_W  = 2 * RT_W;
  localparam int DX_W   = ((B_W + 2) > (rsi_pkg::DIST_W + 1)) ? (B_W + 2)
                                                               : (rsi_pkg::DIST_W + 1);

  // Sphere configuration registers.
  logic signed [CW-1:0] center_x_r, center_y_r, center_z_r;
  logic        [RW-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      radius_r   <= RW'(rsi_pkg::RADIUS_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        rsi_pkg::REG_CENTER_X: center_x_r <= cfg_data;
        rsi_pkg::REG_CENTER_Y: center_y_r <= cfg_data;
        rsi_pkg::REG_CENTER_Z: center_z_r <= cfg_data;
        rsi_pkg::REG_RADIUS:   radius_r   <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless a finished result is held off.
  logic out_valid_r;
  logic en;

  assign en = !out_valid_r || !out_stall;

  // Input skid.
  logic             s_valid;
  logic [PAY_W-1:0] s_data;

  rsi_skid #(
    .W (PAY_W)
  ) u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  ({in_origin_x, in_origin_y, in_origin_z, in_dir_x, in_dir_y, in_dir_z}),
    .en       (en),
    .in_stall (in_stall),
    .s_valid  (s_valid),
    .s_data   (s_data)
  );

  logic signed [CW-1:0] s_origin_x, s_origin_y, s_origin_z;
  logic signed [DW-1:0] s_dir_x, s_dir_y, s_dir_z;

  assign s_origin_x = s_data[PAY_W-1 -: CW];
  assign s_origin_y = s_data[PAY_W-CW-1 -: CW];
  assign s_origin_z = s_data[PAY_W-2*CW-1 -: CW];
  assign s_dir_x    = s_data[3*DW-1 -: DW];
  assign s_dir_y    = s_data[2*DW-1 -: DW];
  assign s_dir_z    = s_data[DW-1:0];

  // Front arithmetic up to the discriminant.
  rsi_pkg::rsi_flags_t   fr_flags;
  logic signed [B_W-1:0] fr_b;
  logic [DISC_W-2:0]     fr_mag;

  rsi_front #(
    .COORD_WIDTH   (COORD_WIDTH),
    .DIR_FRAC_BITS (DIR_FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .s_valid    (s_valid),
    .origin_x   (s_origin_x),
    .origin_y   (s_origin_y),
    .origin_z   (s_origin_z),
    .dir_x      (s_dir_x),
    .dir_y      (s_dir_y),
    .dir_z      (s_dir_z),
    .center_x   (center_x_r),
    .center_y   (center_y_r),
    .center_z   (center_z_r),
    .radius     (radius_r),
    .flags_o    (fr_flags),
    .b_o        (fr_b),
    .disc_mag_o (fr_mag)
  );

  // Square root of the discriminant.
  rsi_pkg::rsi_flags_t   sq_flags;
  logic [RT_W-1:0]       sq_root;
  logic                  sq_rem_nz;
  logic signed [B_W-1:0] sq_b;

  rsi_isqrt #(
    .RT_W (RT_W),
    .B_W  (B_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .flags_i  (fr_flags),
    .rad_i    (RAD_W'(fr_mag)),
    .b_i      (fr_b),
    .flags_o  (sq_flags),
    .root_o   (sq_root),
    .rem_nz_o (sq_rem_nz),
    .b_o      (sq_b)
  );

  // Round the root up, subtract from -b and saturate the distance.
  logic [RT_W:0]                s_ceil;
  logic signed [DX_W-1:0]       dist_q8;
  logic                         dist_neg;
  logic                         dist_over;
  logic                         hit_nxt;
  logic [rsi_pkg::DIST_W-1:0]   dist_nxt;

  always_comb begin
    s_ceil    = (RT_W + 1)'(sq_root) + (RT_W + 1)'(sq_rem_nz);
    dist_q8   = -DX_W'(sq_b) - $signed(DX_W'(s_ceil));
    dist_neg  = dist_q8[DX_W-1];
    dist_over = (dist_q8 > $signed(DX_W'(rsi_pkg::DIST_MAX)));
    hit_nxt   = !sq_flags.disc_neg && !dist_neg;
    if (!hit_nxt) begin
      dist_nxt = '0;
    end else if (dist_over) begin
      dist_nxt = rsi_pkg::DIST_MAX;
    end else begin
      dist_nxt = dist_q8[rsi_pkg::DIST_W-1:0];
    end
  end

  // Output register.
  logic                       out_hit_r;
  logic [rsi_pkg::DIST_W-1:0] out_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq_flags.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r  <= hit_nxt;
      out_dist_r <= dist_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_hit_distance = out_dist_r;

`ifndef SYNTHESIS
  // The skid only fills while a finished result was being held off.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without a held result transaction");

  // A miss always reports a zero distance.
  a_miss_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_hit_distance == '0))
    else $error("miss transaction carries a nonzero distance");
`endif

endmodule

`default_nettype wire

// ===== sv/rsi_skid.sv =====
// Input skid register that keeps the input stall signal a flop output.
`default_nettype none

module rsi_skid #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic [W-1:0] in_data,
  input  wire logic         en,
  output logic              in_stall,
  output logic              s_valid,
  output logic [W-1:0]      s_data
);

  logic         full_r;
  logic         full_nxt;
  logic [W-1:0] hold_r;

  // The buffer fills when a transaction arrives while the pipeline is held,
  // and drains on the first cycle the pipeline moves again.
  always_comb begin
    full_nxt = full_r;
    if (full_r && en) begin
      full_nxt = 1'b0;
    end else if (!full_r && in_valid && !en) begin
      full_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  // Capture the input whenever the buffer is empty; it only matters on a fill.
  always_ff @(posedge clk) begin
    if (!full_r) begin
      hold_r <= in_data;
    end
  end

  assign in_stall = full_r;
  assign s_valid  = full_r | in_valid;
  assign s_data   = full_r ? hold_r : in_data;

endmodule

`default_nettype wire

// ===== sv/rsi_front.sv =====
// Front pipeline: offset, dot product, squared lengths and the discriminant.
`default_nettype none

module rsi_front #(
  parameter int COORD_WIDTH   = rsi_pkg::COORD_WIDTH_DEF,
  parameter int DIR_FRAC_BITS = rsi_pkg::DIR_FRAC_BITS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       en,
  input  wire logic                                       s_valid,
  input  wire logic signed [COORD_WIDTH-1:0]              origin_x,
  input  wire logic signed [COORD_WIDTH-1:0]              origin_y,
  input  wire logic signed [COORD_WIDTH-1:0]              origin_z,
  input  wire logic signed [DIR_FRAC_BITS+1:0]            dir_x,
  input  wire logic signed [DIR_FRAC_BITS+1:0]            dir_y,
  input  wire logic signed [DIR_FRAC_BITS+1:0]            dir_z,
  input  wire logic signed [COORD_WIDTH-1:0]              center_x,
  input  wire logic signed [COORD_WIDTH-1:0]              center_y,
  input  wire logic signed [COORD_WIDTH-1:0]              center_z,
  input  wire logic        [COORD_WIDTH-2:0]              radius,
  output rsi_pkg::rsi_flags_t                             flags_o,
  output logic signed [rsi_pkg::b_width(COORD_WIDTH)-1:0] b_o,
  output logic [rsi_pkg::disc_width(COORD_WIDTH)-2:0]     disc_mag_o
);

  localparam int DW      = DIR_FRAC_BITS + 2;
  localparam int OFF_W   = COORD_WIDTH + 1;
  localparam int RW      = COORD_WIDTH - 1;
  localparam int DOTP_W  = OFF_W + DW;
  localparam int DOT_W   = DOTP_W + 2;
  localparam int SQP_W   = 2 * OFF_W;
  localparam int SQ_W    = SQP_W + 2;
  localparam int R2_W    = 2 * RW;
  localparam int C_W     = SQ_W + 1;
  localparam int B_W     = rsi_pkg::b_width(COORD_WIDTH);
  localparam int B2_W    = 2 * B_W;
  localparam int LO_W    = (B_W + 1) / 2;
  localparam int HI_W    = B_W - LO_W;
  localparam int DISCX_W = B2_W + 2;
  localparam int DISC_W  = rsi_pkg::disc_width(COORD_WIDTH);

  // Stage 1: offset from the sphere center.
  logic                    v1_r;
  logic signed [OFF_W-1:0] off_x_r, off_y_r, off_z_r;
  logic signed [DW-1:0]    dir_x_r, dir_y_r, dir_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off_x_r <= OFF_W'(origin_x) - OFF_W'(center_x);
      off_y_r <= OFF_W'(origin_y) - OFF_W'(center_y);
      off_z_r <= OFF_W'(origin_z) - OFF_W'(center_z);
      dir_x_r <= dir_x;
      dir_y_r <= dir_y;
      dir_z_r <= dir_z;
    end
  end

  // Stage 2: one multiplier per product term.
  logic                     v2_r;
  logic signed [DOTP_W-1:0] dp_x_r, dp_y_r, dp_z_r;
  logic signed [SQP_W-1:0]  sq_x_r, sq_y_r, sq_z_r;
  logic        [R2_W-1:0]   r2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dp_x_r <= off_x_r * dir_x_r;
      dp_y_r <= off_y_r * dir_y_r;
      dp_z_r <= off_z_r * dir_z_r;
      sq_x_r <= off_x_r * off_x_r;
      sq_y_r <= off_y_r * off_y_r;
      sq_z_r <= off_z_r * off_z_r;
      r2_r   <= radius * radius;
    end
  end

  // Stage 3: sum the terms, floor b to Q.8 and form c.
  logic                    v3_r;
  logic signed [DOT_W-1:0] dot_sum;
  logic signed [SQ_W-1:0]  sq_sum;
  logic signed [B_W-1:0]   b3_nxt, b3_r;
  logic signed [C_W-1:0]   c3_nxt, c3_r;

  always_comb begin
    dot_sum = DOT_W'(dp_x_r) + DOT_W'(dp_y_r) + DOT_W'(dp_z_r);
    sq_sum  = SQ_W'(sq_x_r) + SQ_W'(sq_y_r) + SQ_W'(sq_z_r);
    b3_nxt  = dot_sum[DOT_W-1:DIR_FRAC_BITS];
    c3_nxt  = C_W'(sq_sum) - $signed(C_W'(r2_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3_r <= b3_nxt;
      c3_r <= c3_nxt;
    end
  end

  // Stage 4: b*b as partial products of the magnitude halves.
  logic                   v4_r;
  logic [B_W-1:0]         b_abs;
  logic [LO_W-1:0]        b_lo;
  logic [HI_W-1:0]        b_hi;
  logic [2*HI_W-1:0]      pp_hh_r;
  logic [HI_W+LO_W-1:0]   pp_hl_r;
  logic [2*LO_W-1:0]      pp_ll_r;
  logic signed [B_W-1:0]  b4_r;
  logic signed [C_W-1:0]  c4_r;

  always_comb begin
    b_abs = b3_r[B_W-1] ? B_W'(-b3_r) : B_W'(b3_r);
    b_lo  = b_abs[LO_W-1:0];
    b_hi  = b_abs[B_W-1:LO_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh_r <= b_hi * b_hi;
      pp_hl_r <= b_hi * b_lo;
      pp_ll_r <= b_lo * b_lo;
      b4_r    <= b3_r;
      c4_r    <= c3_r;
    end
  end

  // Stage 5: discriminant, taken to its carried width; a negative one is a miss
  // and sends a zero radicand down the root pipeline.
  logic [B2_W-1:0]    b_sq;
  logic [DISCX_W-1:0] disc_x;
  logic [DISC_W-1:0]  disc;
  logic               disc_neg;
  logic [DISC_W-2:0]  mag_nxt;

  rsi_pkg::rsi_flags_t    flags_r;
  logic signed [B_W-1:0]  b5_r;
  logic [DISC_W-2:0]      mag_r;

  always_comb begin
    b_sq     = (B2_W'(pp_hh_r) << (2 * LO_W)) + (B2_W'(pp_hl_r) << (LO_W + 1))
             + B2_W'(pp_ll_r);
    disc_x   = DISCX_W'(b_sq) - DISCX_W'(c4_r);
    disc     = disc_x[DISC_W-1:0];
    disc_neg = disc[DISC_W-1];
    mag_nxt  = disc_neg ? '0 : disc[DISC_W-2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (en) begin
      flags_r.valid    <= v4_r;
      flags_r.disc_neg <= disc_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b5_r  <= b4_r;
      mag_r <= mag_nxt;
    end
  end

  assign flags_o    = flags_r;
  assign b_o        = b5_r;
  assign disc_mag_o = mag_r;

endmodule

`default_nettype wire

// ===== sv/rsi_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, with remainder.
`default_nettype none

module rsi_isqrt #(
  parameter int RT_W = 30,
  parameter int B_W  = 29
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire rsi_pkg::rsi_flags_t   flags_i,
  input  wire logic [2*RT_W-1:0]     rad_i,
  input  wire logic signed [B_W-1:0] b_i,
  output rsi_pkg::rsi_flags_t        flags_o,
  output logic [RT_W-1:0]            root_o,
  output logic                       rem_nz_o,
  output logic signed [B_W-1:0]      b_o
);

  localparam int RAD_W = 2 * RT_W;
  localparam int REM_W = RT_W + 2;

  // Stage k's registers sit at index k.
  rsi_pkg::rsi_flags_t   flags_r [RT_W];
  logic [REM_W-1:0]      rem_r   [RT_W];
  logic [RT_W-1:0]       root_r  [RT_W];
  logic [RAD_W-1:0]      rad_r   [RT_W-1];
  logic signed [B_W-1:0] b_r     [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    rsi_pkg::rsi_flags_t   cur_flags;
    logic [REM_W-1:0]      cur_rem;
    logic [RT_W-1:0]       cur_root;
    logic [RAD_W-1:0]      cur_rad;
    logic signed [B_W-1:0] cur_b;
    logic [REM_W-1:0]      shifted;
    logic [REM_W-1:0]      trial;
    logic [REM_W-1:0]      rem_nxt;
    logic [RT_W-1:0]       root_nxt;
    logic                  ge;

    if (k == 0) begin : g_first
      assign cur_flags = flags_i;
      assign cur_rem   = '0;
      assign cur_root  = '0;
      assign cur_rad   = rad_i;
      assign cur_b     = b_i;
    end else begin : g_next
      assign cur_flags = flags_r[k-1];
      assign cur_rem   = rem_r[k-1];
      assign cur_root  = root_r[k-1];
      assign cur_rad   = rad_r[k-1];
      assign cur_b     = b_r[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    // The remainder entering a stage stays below 2^RT_W, so its top bits
    // are zero and drop out of the shift.
    always_comb begin
      shifted  = {cur_rem[RT_W-1:0], cur_rad[RAD_W-1 -: 2]};
      trial    = {cur_root, 2'b01};
      ge       = (shifted >= trial);
      rem_nxt  = ge ? (shifted - trial) : shifted;
      root_nxt = {cur_root[RT_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        flags_r[k] <= '0;
      end else if (en) begin
        flags_r[k] <= cur_flags;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        b_r[k]    <= cur_b;
      end
    end

    // The last stage has no radicand bits left to pass on.
    if (k < RT_W - 1) begin : g_rad
      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[k] <= {cur_rad[RAD_W-3:0], 2'b00};
        end
      end
    end
  end

  assign flags_o  = flags_r[RT_W-1];
  assign root_o   = root_r[RT_W-1];
  assign rem_nz_o = |rem_r[RT_W-1];
  assign b_o      = b_r[RT_W-1];

`ifndef SYNTHESIS
  // A finished root leaves a remainder of at most twice the root.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    flags_o.valid |-> (rem_r[RT_W-1] <= {1'b0, root_o, 1'b0}))
    else $error("square root remainder exceeds twice the root");

  // A miss enters with a zero radicand and must leave with a zero root.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (flags_o.valid && flags_o.disc_neg) |-> (root_o == '0 && !rem_nz_o))
    else $error("negative discriminant produced a nonzero root");
`endif

endmodule

`default_nettype wire

// ===== sim/ray_sphere_intersect_core_tb.sv =====
// Self-checking testbench for the ray/sphere intersection core: directed and random rays.
`timescale 1ns / 100ps

module ray_sphere_intersect_core_tb;

  localparam int CW = rsi_pkg::COORD_WIDTH_DEF;
  localparam int DW = rsi_pkg::DIR_FRAC_BITS_DEF + 2;
  localparam real COORD_HI = 8388607.0;
  localparam real COORD_LO = -8388608.0;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 48;
  localparam int RAYS_PER_PHASE = 140;

  typedef struct packed {
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic signed [CW-1:0] oz;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
  } ray_t;

  typedef struct packed {
    logic                       hit;
    logic [rsi_pkg::DIST_W-1:0] hit_dist;
  } hit_result_t;

  typedef struct packed {
    logic signed [CW-1:0]       ox;
    logic signed [CW-1:0]       oy;
    logic signed [CW-1:0]       oz;
    logic signed [DW-1:0]       dx;
    logic signed [DW-1:0]       dy;
    logic signed [DW-1:0]       dz;
    logic                       typed;
    logic                       want_hit;
    logic [rsi_pkg::DIST_W-1:0] want_dist;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [rsi_pkg::CFG_IDX_W-1:0] cfg_index = rsi_pkg::REG_CENTER_X;
  logic [CW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] in_origin_x = '0;
  logic signed [CW-1:0] in_origin_y = '0;
  logic signed [CW-1:0] in_origin_z = '0;
  logic signed [DW-1:0] in_dir_x = '0;
  logic signed [DW-1:0] in_dir_y = '0;
  logic signed [DW-1:0] in_dir_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic [rsi_pkg::DIST_W-1:0] out_hit_distance;

  // Local copy of the sphere registers as the core should hold them.
  logic signed [CW-1:0] sph_cx;
  logic signed [CW-1:0] sph_cy;
  logic signed [CW-1:0] sph_cz;
  logic [CW-2:0] sph_r;

  hit_result_t pending_hits[$];
  int error_count = 0;
  int cycle_count = 0;
  bit calm = 1'b0;

  // Directed rays; rows with typed set carry an expectation read off by hand
  // for the reset sphere (center at the origin, radius 1.0).
  stim_row_t directed_rays [18] = '{
    // Hit in front of the ray, along each axis.
    '{0, 0, -1280, 0, 0, 16384, 1, 1, 1024},
    '{1280, 0, 0, -16384, 0, 0, 1, 1, 1024},
    '{0, 1280, 0, 0, -16384, 0, 1, 1, 1024},
    // Sphere behind the ray.
    '{0, 0, -1280, 0, 0, -16384, 1, 0, 0},
    // Ray passes beside the sphere: negative discriminant.
    '{0, 0, -1280, 16384, 0, 0, 1, 0, 0},
    // Origin at the center: nearest root lies behind.
    '{0, 0, 0, 0, 0, 16384, 1, 0, 0},
    // Origin on the surface: zero distance still counts as a hit.
    '{0, 0, -256, 0, 0, 16384, 1, 1, 0},
    // Grazing ray with a small discriminant.
    '{0, 255, -1280, 0, 0, 16384, 0, 0, 0},
    // Field extremes.
    '{8388607, 8388607, 8388607, -9459, -9459, -9459, 0, 0, 0},
    '{-8388608, -8388608, -8388608, 9459, 9459, 9459, 0, 0, 0},
    '{0, 0, -8388608, 0, 0, 16384, 0, 0, 0},
    '{8388607, 8388607, 8388607, -32768, -32768, -32768, 0, 0, 0},
    '{-8388608, -8388608, -8388608, 32767, 32767, 32767, 0, 0, 0},
    '{8388607, -8388608, 0, 0, 0, 16384, 0, 0, 0},
    // Zero direction, inside and outside the sphere.
    '{0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 4096, 0, 0, 0, 0, 0, 0},
    // All-ones fields, the second row with direction extremes mixed in.
    '{-1, -1, -1, -1, -1, -1, 0, 0, 0},
    '{-1, -1, -1, -32768, 32767, -1, 0, 0, 0}
  };

  ray_sphere_intersect_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_origin_x      (in_origin_x),
    .in_origin_y      (in_origin_y),
    .in_origin_z      (in_origin_z),
    .in_dir_x         (in_dir_x),
    .in_dir_y         (in_dir_y),
    .in_dir_z         (in_dir_z),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_hit_distance (out_hit_distance)
  );

  // Free-running clock.
  always #4 clk = ~clk;

  // Smallest root whose square reaches the value, by binary search.
  function automatic longint ceil_root(input longint v);
    longint lo;
    longint hi;
    longint mid;
    lo = 0;
    hi = longint'(1) << 31;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (mid * mid >= v) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  // Nearest nonnegative intersection of a ray with the current sphere.
  function automatic hit_result_t trace_ray(input ray_t r);
    hit_result_t res;
    longint offx;
    longint offy;
    longint offz;
    longint rad;
    longint proj;
    longint cterm;
    longint disc;
    longint reach;
    res = '0;
    offx = longint'(r.ox) - longint'(sph_cx);
    offy = longint'(r.oy) - longint'(sph_cy);
    offz = longint'(r.oz) - longint'(sph_cz);
    rad = longint'(sph_r);
    // Dot product is Q.22; an arithmetic shift floors it back to Q.8.
    proj = (offx * longint'(r.dx) + offy * longint'(r.dy) + offz * longint'(r.dz))
           >>> rsi_pkg::DIR_FRAC_BITS_DEF;
    cterm = offx * offx + offy * offy + offz * offz - rad * rad;
    disc = proj * proj - cterm;
    if (disc < 0) return res;
    reach = -proj - ceil_root(disc);
    if (reach < 0) return res;
    res.hit = 1'b1;
    res.hit_dist = (reach > longint'(rsi_pkg::DIST_MAX)) ? rsi_pkg::DIST_MAX
                                                         : rsi_pkg::DIST_W'(reach);
    return res;
  endfunction

  function automatic real unit_rand();
    return real'(int'($urandom_range(0, 2000)) - 1000) / 1000.0;
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(input real v);
    if (v > COORD_HI) return CW'(8388607);
    if (v < COORD_LO) return CW'(-8388608);
    return CW'($rtoi(v));
  endfunction

  // Mostly rays aimed near the sphere from a random distance; the rest are raw noise.
  function automatic ray_t make_ray();
    ray_t r;
    real ux;
    real uy;
    real uz;
    real len;
    real t;
    real jr;
    int rad;
    if ($urandom_range(0, 99) < 15) begin
      r.ox = CW'($urandom);
      r.oy = CW'($urandom);
      r.oz = CW'($urandom);
      r.dx = DW'($urandom);
      r.dy = DW'($urandom);
      r.dz = DW'($urandom);
      return r;
    end
    do begin
      ux = unit_rand();
      uy = unit_rand();
      uz = unit_rand();
      len = $sqrt(ux * ux + uy * uy + uz * uz);
    end while (len < 0.05);
    ux = ux / len;
    uy = uy / len;
    uz = uz / len;
    rad = int'(sph_r);
    jr = 1.2 * real'(rad);
    case ($urandom_range(0, 3))
      0: t = real'($urandom_range(0, 2 * rad + 256));
      3: t = real'($urandom_range(0, 30000000));
      default: t = real'($urandom_range(0, 4 * rad + 4096));
    endcase
    if ($urandom_range(0, 4) == 0) t = -t;
    r.dx = DW'($rtoi(ux * 16384.0));
    r.dy = DW'($rtoi(uy * 16384.0));
    r.dz = DW'($rtoi(uz * 16384.0));
    r.ox = clamp_coord(real'(sph_cx) + unit_rand() * jr - t * ux);
    r.oy = clamp_coord(real'(sph_cy) + unit_rand() * jr - t * uy);
    r.oz = clamp_coord(real'(sph_cz) + unit_rand() * jr - t * uz);
    return r;
  endfunction

  // Present one ray and hold it until the core takes it. Valid stays high
  // after the transaction unless the next call starts with a gap or a drain follows.
  task automatic send_ray(input ray_t r, input bit typed, input hit_result_t want);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 30);
    end
    in_valid <= 1'b1;
    in_origin_x <= r.ox;
    in_origin_y <= r.oy;
    in_origin_z <= r.oz;
    in_dir_x <= r.dx;
    in_dir_y <= r.dy;
    in_dir_z <= r.dz;
    do @(posedge clk); while (in_stall);
    if (typed) pending_hits.push_back(want);
    else pending_hits.push_back(trace_ray(r));
  endtask

  task automatic send_random_rays(input int count);
    for (int i = 0; i < count; i++) send_ray(make_ray(), 1'b0, '0);
  endtask

  // Drain the pipeline: drop valid, wait for every result back, then let it settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_sphere(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                                input logic [CW-1:0] cz, input logic [CW-1:0] rdata);
    cfg_we <= 1'b1;
    cfg_index <= rsi_pkg::REG_CENTER_X;
    cfg_data <= cx;
    @(posedge clk);
    cfg_index <= rsi_pkg::REG_CENTER_Y;
    cfg_data <= cy;
    @(posedge clk);
    cfg_index <= rsi_pkg::REG_CENTER_Z;
    cfg_data <= cz;
    @(posedge clk);
    cfg_index <= rsi_pkg::REG_RADIUS;
    cfg_data <= rdata;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sph_cx = cx;
    sph_cy = cy;
    sph_cz = cz;
    sph_r = rdata[CW-2:0];
  endtask

  // Result side stalls at random, except during the calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 10);
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    hit_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        $error("unexpected result transaction: hit %0d, hit_distance %0d",
               out_hit, out_hit_distance);
        error_count++;
      end else begin
        want = pending_hits.pop_front();
        if (out_hit !== want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, out_hit);
          error_count++;
        end
        if (out_hit_distance !== want.hit_dist) begin
          $error("hit_distance: expected %0d, actual %0d", want.hit_dist,
                 out_hit_distance);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ray_sphere_intersect_core_tb failed");
      $finish;
    end
  end

  // Main sequence: reset, directed rays, then random rays over several spheres.
  initial begin
    ray_t r;
    hit_result_t want;
    sph_cx = '0;
    sph_cy = '0;
    sph_cz = '0;
    sph_r = (CW-1)'(rsi_pkg::RADIUS_RESET);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rays[i]) begin
      r = '{directed_rays[i].ox, directed_rays[i].oy, directed_rays[i].oz,
            directed_rays[i].dx, directed_rays[i].dy, directed_rays[i].dz};
      want = '{directed_rays[i].want_hit, directed_rays[i].want_dist};
      send_ray(r, directed_rays[i].typed, want);
    end
    send_random_rays(RAYS_PER_PHASE);

    // Moderate sphere somewhere near the origin.
    drain();
    program_sphere(CW'(int'($urandom_range(0, 2097152)) - 1048576),
                   CW'(int'($urandom_range(0, 2097152)) - 1048576),
                   CW'(int'($urandom_range(0, 2097152)) - 1048576),
                   CW'($urandom_range(64, 65536)));
    send_random_rays(RAYS_PER_PHASE);

    // Largest center and radius, with no idling on either side.
    drain();
    program_sphere(CW'(8388607), CW'(8388607), CW'(8388607), CW'(8388607));
    calm = 1'b1;
    send_random_rays(RAYS_PER_PHASE);
    calm = 1'b0;

    // Most negative center and a point-sized sphere.
    drain();
    program_sphere(CW'(-8388608), CW'(-8388608), CW'(-8388608), '0);
    send_random_rays(RAYS_PER_PHASE);

    // Anything goes, including the unused top bit of the radius write.
    drain();
    program_sphere(CW'($urandom), CW'($urandom), CW'($urandom),
                   CW'($urandom) | (CW'(1) << (CW - 1)));
    send_random_rays(RAYS_PER_PHASE);

    // Small sphere close to the origin.
    drain();
    program_sphere(CW'(int'($urandom_range(0, 8192)) - 4096),
                   CW'(int'($urandom_range(0, 8192)) - 4096),
                   CW'(int'($urandom_range(0, 8192)) - 4096),
                   CW'($urandom_range(1, 2048)));
    send_random_rays(RAYS_PER_PHASE);

    drain();
    if (error_count == 0) begin
      $display("ray_sphere_intersect_core_tb passed");
    end else begin
      $display("ray_sphere_intersect_core_tb failed");
    end
    $finish;
  end

endmodule
